@@ rtl/core/wehist_pkg.sv @@
package wehist_pkg;

    localparam int SUM_W  = 48;
    localparam int QUO_W  = 32;
    localparam int STEP_W = 6;
    localparam int MUL_W  = 34;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] ST_BINNED  = 3'd0;
    localparam logic [2:0] ST_SKIPPED = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [CFG_IW-1:0] CFG_T_MIN     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_T_SCALE   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MUB_MIN   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MUB_SCALE = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_T_USED    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MUB_USED  = 3'd5;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] dsigma_0;
        logic signed [23:0] dsigma_1;
        logic signed [23:0] dsigma_2;
        logic signed [23:0] dsigma_3;
        logic signed [23:0] flow_0;
        logic signed [23:0] flow_1;
        logic signed [23:0] flow_2;
        logic signed [23:0] flow_3;
        logic [23:0]        energy_density;
        logic [15:0]        temperature;
        logic [15:0]        baryon_mu;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  temp_bin;
        logic [6:0]  mub_bin;
        logic [31:0] density;
        logic [47:0] total_energy;
        logic        last_bin;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  rem0;
        logic [QUO_W-1:0]  dvd;
        logic [SUM_W-1:0]  dsr;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

@@ rtl/core/wehist_mul.sv @@
module wehist_mul (
    input  logic                                 i_clk,
    input  logic signed [wehist_pkg::MUL_W-1:0]  i_a,
    input  logic signed [wehist_pkg::MUL_W-1:0]  i_b,
    output logic signed [2*wehist_pkg::MUL_W-1:0] o_p
);
    import wehist_pkg::*;

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ rtl/core/wehist_div.sv @@
module wehist_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wehist_pkg::t_div_req        i_req,
    output logic                        o_busy,
    output logic [wehist_pkg::QUO_W-1:0] o_quot,
    output logic [wehist_pkg::SUM_W-1:0] o_rem
);
    import wehist_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_dsr;
    logic [QUO_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quot;
    logic [SUM_W:0]    rem2;
    logic [SUM_W:0]    diff;
    logic              ge;

    always_comb begin
        rem2 = {r_rem, r_dvd[QUO_W-1]};
        diff = rem2 - {1'b0, r_dsr};
        ge   = rem2 >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
            r_rem  <= i_req.rem0;
            r_dvd  <= i_req.dvd;
            r_dsr  <= i_req.dsr;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[SUM_W-1:0] : rem2[SUM_W-1:0];
            r_quot <= {r_quot[QUO_W-2:0], ge};
            r_dvd  <= r_dvd << 1;
            r_cnt  <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/weighted_2d_energy_histogram.sv @@
// Energy-weighted 2D histogram over temperature and baryon potential.
// Input channel: i_in_valid / o_in_stall with payload i_in_data. Operation
// add forms the dot product, energy and bin and updates an in-range bin;
// read returns the next used bin normalized by the total; clear zeroes all.
// Output channel: o_out_valid / i_out_stall with payload o_out_data, one
// transfer per add, read or clear item; operation 3 gives none.
// One item at a time, all data products on one shared 34x34 multiplier and
// all quotients on one bit-serial divider. A clear makes a clearing pass over
// the bin memory, one entry per cycle. The next item is taken in the cycle
// after the result transfer at the earliest. A read with a zero total gives
// density 0; a density that does not fit saturates to all ones. After reset
// the same clearing pass runs while o_in_stall stays high; configuration
// writes are taken at any time. o_in_stall is high while an item is at
// work or a result waits; a stalled receiver holds the result and the block
// takes no new item meanwhile.
module weighted_2d_energy_histogram #(
    parameter int T_BINS   = 128,
    parameter int MUB_BINS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  wehist_pkg::t_in                i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output wehist_pkg::t_out               o_out_data,
    input  logic                           i_cfg_we,
    input  logic [wehist_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [wehist_pkg::CFG_DW-1:0]  i_cfg_data
);
    import wehist_pkg::*;

    localparam int DEPTH = T_BINS * MUB_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int TW    = $clog2(T_BINS);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DOT, S_ESGN, S_TMUL, S_MMUL, S_ICAP, S_ADDR, S_WR,
        S_RCNT, S_RPTR, S_RDS, S_RDW, S_RADR, S_RLO, S_RHI, S_RSUM, S_RSAT, S_RNW
    } t_state;

    t_state            r_state;
    t_in               r_item;
    t_out              r_out;
    logic              r_ovalid;
    logic              r_clr_op;
    logic [AW-1:0]     r_clr_addr;
    logic [2:0]        r_step;
    logic signed [49:0] r_acc;
    logic [SUM_W-1:0]  r_e;
    logic [SUM_W-1:0]  r_sum;
    logic [15:0]       r_it;
    logic [15:0]       r_im;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_count;
    logic              r_last;
    logic [31:0]       r_k;
    logic [55:0]       r_plo;
    logic [79:0]       r_wk;
    logic [15:0]       r_t_min;
    logic [15:0]       r_t_scale;
    logic [15:0]       r_mub_min;
    logic [15:0]       r_mub_scale;
    logic [7:0]        r_t_used;
    logic [7:0]        r_mub_used;

    logic [SUM_W-1:0]  r_mem [DEPTH];
    logic [SUM_W-1:0]  r_rdata;

    logic [7:0]                tu;
    logic [7:0]                mu;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;
    t_div_req                  div_req;
    logic                      div_busy;
    logic [QUO_W-1:0]          div_quot;
    logic [SUM_W-1:0]          div_rem;
    logic [AW-1:0]             addr;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [SUM_W-1:0]          mem_wdata;
    logic [SUM_W:0]            sum_e;
    logic [SUM_W:0]            bin_e;
    logic                      in_range;
    logic [23:0]               ds_sel;
    logic [23:0]               fl_sel;
    logic [CW-1:0]             ptr_inc;

    function automatic logic [7:0] clamp_used(input logic [7:0] v, input int hi);
        logic [7:0] r;
        r = v;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (int'(v) > hi) begin
            r = 8'(hi);
        end
        return r;
    endfunction

    assign tu = clamp_used(r_t_used, T_BINS);
    assign mu = clamp_used(r_mub_used, MUB_BINS);

    assign addr = AW'(r_it[TW-1:0] * MUB_BINS) + AW'(r_im);
    assign sum_e = {1'b0, r_sum} + {1'b0, r_e};
    assign bin_e = {1'b0, r_rdata} + {1'b0, r_e};
    assign ptr_inc = CW'(r_ptr) + CW'(1);
    assign in_range = (r_item.temperature >= r_t_min) && (r_item.baryon_mu >= r_mub_min)
                      && (r_it < 16'(tu)) && (r_im < 16'(mu));

    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                ds_sel = r_item.dsigma_0;
                fl_sel = r_item.flow_0;
            end
            2'd1: begin
                ds_sel = r_item.dsigma_1;
                fl_sel = r_item.flow_1;
            end
            2'd2: begin
                ds_sel = r_item.dsigma_2;
                fl_sel = r_item.flow_2;
            end
            default: begin
                ds_sel = r_item.dsigma_3;
                fl_sel = r_item.flow_3;
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DOT: begin
                mul_a = {{(MUL_W-24){ds_sel[23]}}, ds_sel};
                mul_b = {{(MUL_W-24){fl_sel[23]}}, fl_sel};
            end
            S_ESGN: begin
                mul_a = MUL_W'(r_item.energy_density);
                mul_b = r_acc[49:16];
            end
            S_TMUL: begin
                mul_a = MUL_W'(16'(r_item.temperature - r_t_min));
                mul_b = MUL_W'(r_t_scale);
            end
            S_MMUL: begin
                mul_a = MUL_W'(16'(r_item.baryon_mu - r_mub_min));
                mul_b = MUL_W'(r_mub_scale);
            end
            S_RCNT: begin
                mul_a = MUL_W'(tu);
                mul_b = MUL_W'(mu);
            end
            S_RPTR: begin
                mul_a = MUL_W'(r_t_scale);
                mul_b = MUL_W'(r_mub_scale);
            end
            S_RLO: begin
                mul_a = MUL_W'(r_rdata[23:0]);
                mul_b = MUL_W'(r_k);
            end
            S_RHI: begin
                mul_a = MUL_W'(r_rdata[47:24]);
                mul_b = MUL_W'(r_k);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req = '0;
        if (r_state == S_RDS) begin
            div_req.start = 1'b1;
            div_req.rem0  = '0;
            div_req.dvd   = QUO_W'(r_ptr) << (QUO_W - AW);
            div_req.dsr   = SUM_W'(mu);
            div_req.steps = STEP_W'(AW);
        end else if (r_state == S_RSAT && r_wk < {16'd0, r_sum, 16'd0}) begin
            div_req.start = 1'b1;
            div_req.rem0  = r_wk[63:16];
            div_req.dvd   = {r_wk[15:0], 16'd0};
            div_req.dsr   = r_sum;
            div_req.steps = STEP_W'(QUO_W);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = bin_e[SUM_W] ? '1 : bin_e[SUM_W-1:0];
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_WR) begin
            mem_we = 1'b1;
        end
    end

    wehist_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    wehist_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_ovalid    <= 1'b0;
            r_sum       <= '0;
            r_ptr       <= '0;
            r_t_min     <= 16'd0;
            r_t_scale   <= 16'd500;
            r_mub_min   <= 16'd0;
            r_mub_scale <= 16'd100;
            r_t_used    <= 8'd100;
            r_mub_used  <= 8'd90;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_T_MIN:     r_t_min     <= i_cfg_data;
                    CFG_T_SCALE:   r_t_scale   <= i_cfg_data;
                    CFG_MUB_MIN:   r_mub_min   <= i_cfg_data;
                    CFG_MUB_SCALE: r_mub_scale <= i_cfg_data;
                    CFG_T_USED:    r_t_used    <= i_cfg_data[7:0];
                    CFG_MUB_USED:  r_mub_used  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                        if (r_clr_op) begin
                            r_ovalid <= 1'b1;
                            r_out    <= '{status: ST_CLEARED, temp_bin: 7'd0, mub_bin: 7'd0,
                                          density: 32'd0, total_energy: r_sum,
                                          last_bin: 1'b0};
                        end
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && !r_ovalid) begin
                        r_item <= i_in_data;
                        r_step <= 3'd0;
                        r_acc  <= '0;
                        case (i_in_data.operation)
                            OP_ADD:  r_state <= S_DOT;
                            OP_READ: r_state <= S_RCNT;
                            OP_CLEAR: begin
                                r_state    <= S_CLR;
                                r_clr_addr <= '0;
                                r_clr_op   <= 1'b1;
                                r_sum      <= '0;
                                r_ptr      <= '0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DOT: begin
                    if (r_step != 3'd0) begin
                        r_acc <= r_acc + prod[49:0];
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        r_state <= S_ESGN;
                    end
                end
                S_ESGN: begin
                    if (r_acc[49]) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: ST_SKIPPED, temp_bin: 7'd0, mub_bin: 7'd0,
                                      density: 32'd0, total_energy: r_sum, last_bin: 1'b0};
                    end else begin
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_e     <= prod[63:16];
                    r_state <= S_MMUL;
                end
                S_MMUL: begin
                    r_it    <= prod[31:16];
                    r_state <= S_ICAP;
                end
                S_ICAP: begin
                    r_im    <= prod[31:16];
                    r_sum   <= sum_e[SUM_W] ? '1 : sum_e[SUM_W-1:0];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (in_range) begin
                        r_state <= S_WR;
                    end else begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: ST_RANGE, temp_bin: 7'd0, mub_bin: 7'd0,
                                      density: 32'd0, total_energy: r_sum, last_bin: 1'b0};
                    end
                end
                S_WR: begin
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b1;
                    r_out    <= '{status: ST_BINNED, temp_bin: r_it[6:0], mub_bin: r_im[6:0],
                                  density: 32'd0, total_energy: r_sum, last_bin: 1'b0};
                end
                S_RCNT: begin
                    r_state <= S_RPTR;
                end
                S_RPTR: begin
                    r_count <= prod[CW-1:0];
                    if (CW'(r_ptr) >= prod[CW-1:0]) begin
                        r_ptr <= '0;
                    end
                    r_state <= S_RDS;
                end
                S_RDS: begin
                    r_k     <= prod[31:0];
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    if (!div_busy) begin
                        r_it    <= div_quot[15:0];
                        r_im    <= div_rem[15:0];
                        r_state <= S_RADR;
                    end
                end
                S_RADR: begin
                    if (ptr_inc >= r_count) begin
                        r_ptr  <= '0;
                        r_last <= 1'b1;
                    end else begin
                        r_ptr  <= ptr_inc[AW-1:0];
                        r_last <= 1'b0;
                    end
                    if (r_sum == '0) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: ST_ZERO, temp_bin: r_it[6:0],
                                      mub_bin: r_im[6:0], density: 32'd0,
                                      total_energy: r_sum, last_bin: ptr_inc >= r_count};
                    end else begin
                        r_state <= S_RLO;
                    end
                end
                S_RLO: begin
                    r_state <= S_RHI;
                end
                S_RHI: begin
                    r_plo   <= prod[55:0];
                    r_state <= S_RSUM;
                end
                S_RSUM: begin
                    r_wk    <= 80'(r_plo) + {prod[55:0], 24'd0};
                    r_state <= S_RSAT;
                end
                S_RSAT: begin
                    if (div_req.start) begin
                        r_state <= S_RNW;
                    end else begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: ST_READ, temp_bin: r_it[6:0],
                                      mub_bin: r_im[6:0], density: '1,
                                      total_energy: r_sum, last_bin: r_last};
                    end
                end
                S_RNW: begin
                    if (!div_busy) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: ST_READ, temp_bin: r_it[6:0],
                                      mub_bin: r_im[6:0], density: div_quot,
                                      total_energy: r_sum, last_bin: r_last};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result waits");

    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.operation != OP_NOP) |=> o_in_stall)
        else $error("block idle right after taking an item");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

endmodule
